FILE: hdl/prpo_pkg.sv
// Package for the palette pixel output unit: item types, register codes,
// read modes and the cell-to-index mapping. Depends on nothing.
`default_nettype none
package prpo_pkg;

	localparam int PAL_DEPTH = 32;
	localparam int PAL_AW    = 5;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_PIXEL = 2'd2;

	localparam logic [4:0] REG_BG     = 5'h00;
	localparam logic [4:0] REG_STATUS = 5'h08;
	localparam logic [4:0] REG_CTRL   = 5'h1C;

	localparam logic [1:0] MODE_INTERLEAVE = 2'd2;
	localparam logic [1:0] MODE_ONE_BIT    = 2'd3;

	localparam logic [7:0] KILL_MASK = 8'h0F;

	typedef struct packed {
		logic [1:0] operation;
		logic [4:0] reg_addr;
		logic [7:0] write_data;
		logic       vertical_blank;
		logic [4:0] cell_req;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] left_pixel;
		logic [7:0] right_pixel;
	} rsp_t;

	// Everything the color stage needs besides the palette read data.
	typedef struct packed {
		logic       pixel;
		logic       kill;
		logic [7:0] bg;
		logic       left_bg;
		logic       left_valid;
		logic       right_bg;
		logic       right_valid;
		logic [7:0] read_data;
	} stage_t;

	// Decoded controls from the front end.
	typedef struct packed {
		logic              wr_en;
		logic [PAL_AW-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic [PAL_AW-1:0] left_addr;
		logic [PAL_AW-1:0] right_addr;
		stage_t            info;
	} ctrl_t;

	function automatic logic [PAL_AW-1:0] left_index(input logic [1:0] mode,
		input logic [4:0] cell_bits);
		logic [PAL_AW-1:0] idx;
		case (mode)
			MODE_INTERLEAVE: idx = {cell_bits[4], 2'b00, cell_bits[1], cell_bits[3]};
			MODE_ONE_BIT:    idx = {cell_bits[4:2], cell_bits[1], 1'b0};
			default:         idx = cell_bits;
		endcase
		return idx;
	endfunction

	function automatic logic [PAL_AW-1:0] right_index(input logic [1:0] mode,
		input logic [4:0] cell_bits);
		logic [PAL_AW-1:0] idx;
		case (mode)
			MODE_INTERLEAVE: idx = {cell_bits[4], 2'b00, cell_bits[0], cell_bits[2]};
			MODE_ONE_BIT:    idx = {cell_bits[4:2], cell_bits[0], 1'b0};
			default:         idx = cell_bits;
		endcase
		return idx;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/palette_register_pixel_output_unit.sv
// Top level of the palette pixel output unit: stage register, palette RAM,
// color stage and result register. Uses prpo_pkg, prpo_ctrl, prpo_ram, prpo_colour.
`default_nettype none
// Each item is a bus register write, a bus register read or one line-buffer
// cell, and each yields exactly one result item. The unit takes one item every
// cycle unless stalled, passing the stage and result registers, at one item
// per cycle sustained while the result side keeps taking. Writes and control
// changes take effect for the very next item. The palette lives in a small
// dual-read RAM; the slots whose index is a multiple of four always hold the
// same value and are kept in one background register instead. Palette entries
// not yet written read as zero through per-entry valid bits cleared at reset,
// so no clearing pass is needed. A full result register stalls only the stage
// register behind it, and the unit stops taking items only when both are full.
module palette_register_pixel_output_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire prpo_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output prpo_pkg::rsp_t      rsp
);

	prpo_pkg::ctrl_t  ctrl;
	prpo_pkg::stage_t info_s1;
	prpo_pkg::rsp_t   result;
	prpo_pkg::rsp_t   rsp_q;
	logic             valid_s1;
	logic             rsp_valid_q;
	logic             req_accept;
	logic             s1_advance;
	logic [7:0]       left_data_s1;
	logic [7:0]       right_data_s1;

	// The stage register moves on whenever the result register is free or
	// being emptied in this cycle.
	assign s1_advance = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready  = !valid_s1 || s1_advance;
	assign req_accept = req_valid && req_ready;

	prpo_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (req_accept),
		.req    (req),
		.ctrl   (ctrl)
	);

	// Read data is captured with the item, so it stays with the stage
	// register while that is stalled.
	prpo_ram #(
		.WIDTH (8),
		.DEPTH (prpo_pkg::PAL_DEPTH)
	) u_pal_ram (
		.clk     (clk),
		.we      (ctrl.wr_en),
		.waddr   (ctrl.wr_addr),
		.wdata   (ctrl.wr_data),
		.re      (req_accept),
		.raddr_a (ctrl.left_addr),
		.raddr_b (ctrl.right_addr),
		.rdata_a (left_data_s1),
		.rdata_b (right_data_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_advance) begin
				valid_s1 <= 1'b0;
			end
			if (s1_advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			info_s1 <= ctrl.info;
		end
		if (s1_advance) begin
			rsp_q <= result;
		end
	end

	prpo_colour u_colour (
		.info       (info_s1),
		.left_data  (left_data_s1),
		.right_data (right_data_s1),
		.rsp        (result)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A control write must show up in the kill bit seen by the next item.
	a_ctrl_kill: assert property (@(posedge clk) disable iff (!arst_n)
		(req_accept && req.operation == prpo_pkg::OP_WRITE
			&& req.reg_addr == prpo_pkg::REG_CTRL)
		|=> (ctrl.info.kill == $past(req.write_data[7])))
		else $error("color kill latch did not follow control write");

	// Both stages full and output stalled: no new item may be taken.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && rsp_valid_q && !rsp_ready) |-> !req_ready)
		else $error("item accepted while both stages are full");

	// Items other than pixel cells never carry pixel colors.
	a_non_pixel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !info_s1.pixel) |-> (result.left_pixel == 8'h00
			&& result.right_pixel == 8'h00))
		else $error("non-pixel item produced pixel colors");

	// A result register that is stalled keeps its item.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |=> (rsp_valid_q && $stable(rsp_q)))
		else $error("stalled result changed");

endmodule
`default_nettype wire

FILE: hdl/prpo_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// Depends on nothing.
`default_nettype none
module prpo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/prpo_ctrl.sv
// Front end of the palette pixel output unit: bus decode, control latch,
// background color, palette valid bits and index mapping. Uses prpo_pkg.
`default_nettype none
module prpo_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire prpo_pkg::req_t  req,
	output prpo_pkg::ctrl_t      ctrl
);

	logic                           kill_q;
	logic [1:0]                     mode_q;
	logic [7:0]                     bg_q;
	logic [prpo_pkg::PAL_DEPTH-1:0] valid_q;

	logic is_write;
	logic wr_ctrl;
	logic wr_bg;
	logic wr_pal;
	logic [prpo_pkg::PAL_AW-1:0] li;
	logic [prpo_pkg::PAL_AW-1:0] ri;

	assign is_write = accept && (req.operation == prpo_pkg::OP_WRITE);
	assign wr_bg    = is_write && (req.reg_addr == prpo_pkg::REG_BG);
	assign wr_ctrl  = is_write && (req.reg_addr == prpo_pkg::REG_CTRL);
	assign wr_pal   = is_write && (req.reg_addr[1:0] != 2'b00);

	assign li = prpo_pkg::left_index(mode_q, req.cell_req);
	assign ri = prpo_pkg::right_index(mode_q, req.cell_req);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kill_q  <= 1'b0;
			mode_q  <= 2'b00;
			bg_q    <= 8'h00;
			valid_q <= '0;
		end else begin
			if (wr_ctrl) begin
				kill_q <= req.write_data[7];
				mode_q <= req.write_data[1:0];
			end
			if (wr_bg) begin
				bg_q <= req.write_data;
			end
			if (wr_pal) begin
				valid_q[req.reg_addr] <= 1'b1;
			end
		end
	end

	always_comb begin
		ctrl.wr_en            = wr_pal;
		ctrl.wr_addr          = req.reg_addr;
		ctrl.wr_data          = req.write_data;
		ctrl.left_addr        = li;
		ctrl.right_addr       = ri;
		ctrl.info.pixel       = (req.operation == prpo_pkg::OP_PIXEL);
		ctrl.info.kill        = kill_q;
		ctrl.info.bg          = bg_q;
		ctrl.info.left_bg     = (li[1:0] == 2'b00);
		ctrl.info.left_valid  = valid_q[li];
		ctrl.info.right_bg    = (ri[1:0] == 2'b00);
		ctrl.info.right_valid = valid_q[ri];
		ctrl.info.read_data   = 8'h00;
		if ((req.operation == prpo_pkg::OP_READ)
			&& (req.reg_addr == prpo_pkg::REG_STATUS)) begin
			ctrl.info.read_data = {req.vertical_blank, 7'b0};
		end
	end

endmodule
`default_nettype wire

FILE: hdl/prpo_colour.sv
// Color stage: picks background, palette entry or reset value for each
// pixel and applies color kill. Uses prpo_pkg.
`default_nettype none
module prpo_colour (
	input  wire prpo_pkg::stage_t info,
	input  wire logic [7:0]       left_data,
	input  wire logic [7:0]       right_data,
	output prpo_pkg::rsp_t        rsp
);

	logic [7:0] lc;
	logic [7:0] rc;
	logic [7:0] mask;

	always_comb begin
		if (info.left_bg) begin
			lc = info.bg;
		end else begin
			lc = info.left_valid ? left_data : 8'h00;
		end
		if (info.right_bg) begin
			rc = info.bg;
		end else begin
			rc = info.right_valid ? right_data : 8'h00;
		end
		mask = info.kill ? prpo_pkg::KILL_MASK : 8'hFF;
		rsp.read_data   = info.read_data;
		rsp.left_pixel  = info.pixel ? (lc & mask) : 8'h00;
		rsp.right_pixel = info.pixel ? (rc & mask) : 8'h00;
	end

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the palette pixel output unit: a directed table, back pressure and
// four random idling phases, checked by typed answers or a cycle-free predictor.
// Depends on prpo_pkg and palette_register_pixel_output_unit.
module tb_top;

	// The spare operation code is not named in the package. It must change
	// nothing and still return one all-zero item.
	localparam logic [1:0] OP_SPARE = 2'd3;
	// Read modes 0 and 1 both use the cell itself as the palette index.
	localparam logic [1:0] MODE_CELL_A = 2'd0;
	localparam logic [1:0] MODE_CELL_B = 2'd1;

	localparam prpo_pkg::rsp_t RSP_ZERO = '0;
	localparam prpo_pkg::rsp_t RSP_VBLANK =
		'{read_data: 8'h80, left_pixel: 8'h00, right_pixel: 8'h00};

	localparam int RANDOM_PER_PHASE = 400;
	localparam int HOLD_CYCLES      = 300;
	localparam int PRESSURE_ITEMS   = 40;
	localparam int TAIL_CYCLES      = 10;
	localparam int QUIET_LIMIT      = 4000;
	localparam int MAX_REPORTS      = 10;

	typedef struct {
		prpo_pkg::req_t item;
		bit             fixed;
		prpo_pkg::rsp_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	prpo_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	prpo_pkg::rsp_t rsp;

	// Shadow copy of the unit's state, updated in acceptance order.
	logic [7:0] pal_shadow [prpo_pkg::PAL_DEPTH];
	logic       kill_shadow;
	logic [1:0] mode_shadow;

	// Results still owed by the unit, oldest first.
	prpo_pkg::rsp_t awaited_rsp [$];
	stim_row_t stim_rows [$];

	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int hold_asks = 0;
	int fail_count = 0;
	int quiet_cycles = 0;
	prpo_pkg::rsp_t oldest;

	palette_register_pixel_output_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic prpo_pkg::req_t pack_req(input logic [1:0] op,
		input logic [4:0] addr, input logic [7:0] data, input logic vb,
		input logic [4:0] cell_bits);
		prpo_pkg::req_t r;
		r.operation      = op;
		r.reg_addr       = addr;
		r.write_data     = data;
		r.vertical_blank = vb;
		r.cell_req       = cell_bits;
		return r;
	endfunction

	function automatic stim_row_t stim_row(input prpo_pkg::req_t item, input bit fixed,
		input prpo_pkg::rsp_t want);
		stim_row_t s;
		s.item  = item;
		s.fixed = fixed;
		s.want  = want;
		return s;
	endfunction

	// Control byte: color kill in bit 7, read mode in bits 1..0. The bits in
	// between carry junk on purpose, since the unit must ignore them.
	function automatic logic [7:0] ctrl_byte(input logic kill, input logic [1:0] mode);
		return {kill, 5'b10101, mode};
	endfunction

	// Computes the result of one accepted item and applies its side effects to
	// the shadow state. Writes to the background register fan out to every
	// slot whose index is a multiple of four.
	function automatic prpo_pkg::rsp_t colour_of_item(input prpo_pkg::req_t r);
		prpo_pkg::rsp_t o;
		logic [4:0]     li;
		logic [4:0]     ri;
		logic [7:0]     lc;
		logic [7:0]     rc;
		o = '0;
		case (r.operation)
			prpo_pkg::OP_WRITE: begin
				if (r.reg_addr == prpo_pkg::REG_BG) begin
					for (int i = 0; i < prpo_pkg::PAL_DEPTH; i += 4)
						pal_shadow[i] = r.write_data;
				end else if (r.reg_addr == prpo_pkg::REG_CTRL) begin
					kill_shadow = r.write_data[7];
					mode_shadow = r.write_data[1:0];
				end else if (r.reg_addr[1:0] != 2'b00) begin
					pal_shadow[r.reg_addr] = r.write_data;
				end
			end
			prpo_pkg::OP_READ: begin
				if (r.reg_addr == prpo_pkg::REG_STATUS)
					o.read_data = {r.vertical_blank, 7'b0};
			end
			prpo_pkg::OP_PIXEL: begin
				if (mode_shadow == prpo_pkg::MODE_INTERLEAVE) begin
					li = {r.cell_req[4], 2'b00, r.cell_req[1], r.cell_req[3]};
					ri = {r.cell_req[4], 2'b00, r.cell_req[0], r.cell_req[2]};
				end else if (mode_shadow == prpo_pkg::MODE_ONE_BIT) begin
					li = {r.cell_req[4:2], r.cell_req[1], 1'b0};
					ri = {r.cell_req[4:2], r.cell_req[0], 1'b0};
				end else begin
					li = r.cell_req;
					ri = r.cell_req;
				end
				lc = pal_shadow[li];
				rc = pal_shadow[ri];
				if (kill_shadow) begin
					lc = lc & prpo_pkg::KILL_MASK;
					rc = rc & prpo_pkg::KILL_MASK;
				end
				o.left_pixel  = lc;
				o.right_pixel = rc;
			end
			default: ;
		endcase
		return o;
	endfunction

	// Random items lean toward palette and control writes followed by pixels,
	// so that every read mode meets a palette full of distinct values. Fields
	// an operation does not use are random noise all the same.
	function automatic prpo_pkg::req_t random_item();
		prpo_pkg::req_t r;
		int             pick;
		r = pack_req(prpo_pkg::OP_PIXEL, 5'($urandom_range(31)), 8'($urandom_range(255)),
			1'($urandom_range(1)), 5'($urandom_range(31)));
		pick = $urandom_range(99);
		if (pick < 30) begin
			r.operation = prpo_pkg::OP_WRITE;
			case ($urandom_range(9))
				0:       r.reg_addr = prpo_pkg::REG_CTRL;
				1:       r.reg_addr = prpo_pkg::REG_BG;
				default: ;
			endcase
		end else if (pick < 45) begin
			r.operation = prpo_pkg::OP_READ;
			if ($urandom_range(1) == 0)
				r.reg_addr = prpo_pkg::REG_STATUS;
		end else if (pick >= 96) begin
			r.operation = OP_SPARE;
		end
		return r;
	endfunction

	// Offers one item and returns at the edge where it is taken. Valid stays
	// high between back-to-back items and drops only for a gap. Must be called
	// right after a rising edge.
	task automatic offer(input prpo_pkg::req_t item, input bit fixed,
		input prpo_pkg::rsp_t want);
		prpo_pkg::rsp_t due;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		// The predictor always runs so the shadow state stays in step; rows
		// with a hand-written answer override only the comparison value.
		due = colour_of_item(item);
		if (fixed)
			due = want;
		awaited_rsp.push_back(due);
	endtask

	// Lowers valid and waits until the unit has returned everything it owes.
	task automatic drain();
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0)
			@(posedge clk);
	endtask

	// Result side. A hold-off asked for by the main sequence keeps ready low
	// for a long stretch, counted here, so the unit fills and stalls its input.
	initial begin : rsp_side
		int served;
		served = 0;
		@(posedge clk);
		forever begin
			if (hold_asks != served) begin
				served++;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp_ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
				@(posedge clk);
			end
		end
	end

	// Result checker. Each item taken from the unit is compared field by
	// field against the oldest awaited result.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_rsp.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected result item: read %h left %h right %h",
						rsp.read_data, rsp.left_pixel, rsp.right_pixel);
			end else begin
				oldest = awaited_rsp.pop_front();
				if (rsp.read_data !== oldest.read_data ||
					rsp.left_pixel !== oldest.left_pixel ||
					rsp.right_pixel !== oldest.right_pixel) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display({"result mismatch: read %h/%h left %h/%h ",
							"right %h/%h (expected/actual)"},
							oldest.read_data, rsp.read_data, oldest.left_pixel,
							rsp.left_pixel, oldest.right_pixel, rsp.right_pixel);
				end
			end
		end
	end

	// Watchdog: a long run of cycles with no item moving on either side means
	// the unit has hung.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : main_seq
		for (int i = 0; i < prpo_pkg::PAL_DEPTH; i++)
			pal_shadow[i] = 8'h00;
		kill_shadow = 1'b0;
		mode_shadow = MODE_CELL_A;

		// Directed table. Rows with a typed answer cover reset contents, the
		// status read, reads of other registers, the spare operation and the
		// fact that writes return zero. The rest go through the predictor.
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_PIXEL, 5'h00, 8'h00, 1'b0,
			5'h00), 1'b1, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_PIXEL, 5'h1F, 8'hFF, 1'b1,
			5'h1F), 1'b1, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_READ, prpo_pkg::REG_STATUS,
			8'h00, 1'b1, 5'h00), 1'b1, RSP_VBLANK));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_READ, prpo_pkg::REG_STATUS,
			8'hFF, 1'b0, 5'h1F), 1'b1, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_READ, 5'h1F, 8'hFF, 1'b1,
			5'h1F), 1'b1, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_READ, prpo_pkg::REG_CTRL,
			8'h00, 1'b1, 5'h00), 1'b1, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(OP_SPARE, 5'h1F, 8'hFF, 1'b1,
			5'h1F), 1'b1, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_WRITE, prpo_pkg::REG_BG,
			8'hFF, 1'b1, 5'h1F), 1'b1, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_WRITE, 5'h01, 8'hA5, 1'b0,
			5'h00), 1'b1, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_WRITE, 5'h1F, 8'h5A, 1'b0,
			5'h00), 1'b1, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_WRITE, 5'h02, 8'h3C, 1'b0,
			5'h00), 1'b1, RSP_ZERO));
		// A write to a multiple-of-four register other than background or control is dropped.
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_WRITE, 5'h04, 8'h77, 1'b1,
			5'h00), 1'b1, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_PIXEL, 5'h00, 8'h00, 1'b0,
			5'h04), 1'b0, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_PIXEL, 5'h00, 8'h00, 1'b0,
			5'h01), 1'b0, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_PIXEL, 5'h00, 8'h00, 1'b0,
			5'h1F), 1'b0, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_WRITE, prpo_pkg::REG_CTRL,
			ctrl_byte(1'b1, prpo_pkg::MODE_INTERLEAVE), 1'b0, 5'h00), 1'b1, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_PIXEL, 5'h00, 8'h00, 1'b0,
			5'h1F), 1'b0, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_PIXEL, 5'h00, 8'h00, 1'b0,
			5'h0A), 1'b0, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_WRITE, prpo_pkg::REG_CTRL,
			ctrl_byte(1'b0, prpo_pkg::MODE_ONE_BIT), 1'b0, 5'h00), 1'b1, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_PIXEL, 5'h00, 8'h00, 1'b0,
			5'h1F), 1'b0, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_PIXEL, 5'h00, 8'h00, 1'b0,
			5'h15), 1'b0, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_WRITE, prpo_pkg::REG_CTRL,
			ctrl_byte(1'b1, MODE_CELL_B), 1'b0, 5'h00), 1'b1, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_PIXEL, 5'h00, 8'h00, 1'b0,
			5'h13), 1'b0, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_WRITE, prpo_pkg::REG_CTRL,
			ctrl_byte(1'b0, MODE_CELL_A), 1'b0, 5'h00), 1'b1, RSP_ZERO));
		stim_rows.push_back(stim_row(pack_req(prpo_pkg::OP_PIXEL, 5'h00, 8'h00, 1'b1,
			5'h02), 1'b0, RSP_ZERO));

		// Reset is held at the start and released on a rising edge.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i])
			offer(stim_rows[i].item, stim_rows[i].fixed, stim_rows[i].want);

		// The sender pauses until every result is back.
		drain();

		// Back pressure: the result side holds off while items keep coming,
		// so the stage and result registers fill and input ready drops.
		hold_asks++;
		repeat (PRESSURE_ITEMS)
			offer(random_item(), 1'b0, RSP_ZERO);

		// Random phases: no idling, sender idle, receiver stalling, both.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
				1: begin send_idle_pct = 64; rsp_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  rsp_stall_pct = 64; end
				default: begin send_idle_pct = 10; rsp_stall_pct = 10; end
			endcase
			repeat (RANDOM_PER_PHASE)
				offer(random_item(), 1'b0, RSP_ZERO);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && awaited_rsp.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
